// ===== hw/rtl/mecanum_wheel_speed_controller_top_defines.svh =====
// Assertion macros for the mecanum wheel speed controller RTL, used by mwsc_ctrl.
// Depends on a clock named clk and a synchronous reset named rst in the using scope.
`ifndef MECANUM_WHEEL_SPEED_CONTROLLER_TOP_DEFINES_SVH
`define MECANUM_WHEEL_SPEED_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MWSC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MWSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mwsc_pkg.sv =====
// Package for the mecanum wheel speed controller: widths, field offsets,
// register indexes, controller states and the controller-to-datapath command.
package mwsc_pkg;

  localparam int WHEELS       = 4;
  localparam int WHEEL_W      = 2;
  localparam int CNT_BITS_DEF = 32;

  localparam int Q_W     = 16;  // Q8.8 command and speed width
  localparam int TERM_W  = 17;  // rotation term after the 16-bit shift
  localparam int ERR_W   = 20;  // target minus speed, full width
  localparam int PWM_W   = 9;
  localparam int MAG_W   = 8;
  localparam int MULB_W  = 17;  // second multiplier operand, signed

  localparam int SCALE_W  = 16;
  localparam int LEVER_W  = 16;
  localparam int GAIN_W   = 10;
  localparam int THRESH_W = 15;

  localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(100);
  localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(3);

  localparam logic signed [Q_W-1:0] SPEED_MAX = 16'sh7FFF;
  localparam logic signed [Q_W-1:0] SPEED_MIN = 16'sh8000;
  localparam logic [MAG_W-1:0]      PWM_MAX   = 8'd255;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_LEVER      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOVING_THRESHOLD = 3'd3;

  // Input tdata layout.
  localparam int IN_TDATA_W = 56;
  localparam int IN_WHEEL_LSB = 0;
  localparam int IN_ON_A_BIT  = 2;
  localparam int IN_LVL_A_BIT = 3;
  localparam int IN_LVL_B_BIT = 4;
  localparam int IN_FWD_LSB   = 5;
  localparam int IN_STR_LSB   = 21;
  localparam int IN_TURN_LSB  = 37;

  // Output tdata: four PWM values then the moving mask.
  localparam int OUT_TDATA_W = WHEELS * PWM_W + WHEELS;

  // Sign pattern of mecanum inverse kinematics, bit i for wheel i:
  // strafe is added on front right and rear left, rotation on the right side.
  localparam logic [WHEELS-1:0] STR_ADD  = 4'b0110;
  localparam logic [WHEELS-1:0] TERM_ADD = 4'b1010;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TERM_MUL,
    S_TERM_LD,
    S_SPEED_MUL,
    S_ERR,
    S_PWM_MUL,
    S_PWM_LD,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_TERM,
    MUL_SPEED,
    MUL_PWM
  } mul_sel_t;

  typedef struct packed {
    logic               in_ld;      // latch the command fields of a tick
    logic               edge_step;  // count one encoder edge
    logic               mul_en;
    mul_sel_t           mul_sel;
    logic               sample;     // take the count difference, resample
    logic               term_ld;
    logic               err_ld;
    logic               pwm_ld;
    logic               out_ld;
    logic [WHEEL_W-1:0] wheel;
  } dp_cmd_t;

endpackage

// ===== hw/rtl/mecanum_wheel_speed_controller_top.sv =====
// Mecanum wheel speed controller top: mwsc_ctrl and mwsc_datapath, built on mwsc_pkg.
// Edge transaction: counted at the edge that accepts it; accepted back to back while idle.
// Tick transaction: no new item is taken until its result is loaded and the FSM is idle.
// One shared multiplier computes the rotation term, then two products per wheel, registered.
// A result waiting in the output register holds off only the end of the next tick.
// Synchronous rst clears the counts and the output valid and restores register defaults.
module mecanum_wheel_speed_controller_top
  import mwsc_pkg::*;
#(
  parameter int COUNT_BITS = CNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // wheel[1:0], edge_on_a, level_a, level_b, cmd_forward, cmd_strafe, cmd_turn, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // func
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // drive_front_left, drive_front_right, drive_rear_left, drive_rear_right, moving_mask
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  dp_cmd_t cmd;

  mwsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  mwsc_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (m_tdata)
  );

endmodule

// ===== hw/rtl/mwsc_datapath.sv =====
// Datapath of the mecanum wheel speed controller: edge counters, config
// registers, one shared multiplier and the result registers. Uses mwsc_pkg.
module mwsc_datapath
  import mwsc_pkg::*;
#(
  parameter int COUNT_BITS = CNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int MA = (COUNT_BITS > ERR_W) ? COUNT_BITS : ERR_W;
  localparam int PW = MA + MULB_W;

  logic [SCALE_W-1:0]  speed_scale;
  logic [LEVER_W-1:0]  wheel_lever;
  logic [GAIN_W-1:0]   prop_gain;
  logic [THRESH_W-1:0] moving_threshold;

  logic [COUNT_BITS-1:0] edge_count    [WHEELS];
  logic [COUNT_BITS-1:0] sampled_count [WHEELS];

  logic signed [Q_W-1:0]    fwd, str, turn;
  logic signed [TERM_W-1:0] term;
  logic signed [ERR_W-1:0]  err;
  logic signed [PW-1:0]     product;
  logic [PWM_W-1:0]         pwm [WHEELS];
  logic [WHEELS-1:0]        mask;
  logic [OUT_TDATA_W-1:0]   out_reg;

  logic [WHEEL_W-1:0]           in_wheel;
  logic                         in_up;
  logic signed [COUNT_BITS-1:0] diff;
  logic signed [MA-1:0]         mul_a;
  logic signed [MULB_W-1:0]     mul_b;
  logic signed [Q_W-1:0]        speed;
  logic [Q_W:0]                 speed_mag;
  logic signed [ERR_W-1:0]      str_e, term_e, target, err_next;
  logic                         p_neg;
  logic [PW-1:0]                p_abs;
  logic [MAG_W-1:0]             p_mag;
  logic [PWM_W-1:0]             pwm_next;

  // Quadrature direction of the edge on the input bus.
  assign in_wheel = s_tdata[IN_WHEEL_LSB +: WHEEL_W];
  assign in_up = s_tdata[IN_ON_A_BIT]
               ? (s_tdata[IN_LVL_A_BIT] ^ s_tdata[IN_LVL_B_BIT])
               : ~(s_tdata[IN_LVL_A_BIT] ^ s_tdata[IN_LVL_B_BIT]);

  assign diff = edge_count[cmd.wheel] - sampled_count[cmd.wheel];

  always_comb begin
    case (cmd.mul_sel)
      MUL_TERM: begin
        mul_a = MA'(turn);
        mul_b = signed'(MULB_W'(wheel_lever));
      end
      MUL_SPEED: begin
        mul_a = MA'(diff);
        mul_b = signed'(MULB_W'(speed_scale));
      end
      MUL_PWM: begin
        mul_a = MA'(err);
        mul_b = signed'(MULB_W'(prop_gain));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Speed: floor of the scaled difference, saturated to Q8.8.
  always_comb begin
    if ((&product[PW-1:31]) || !(|product[PW-1:31])) begin
      speed = product[31:16];
    end else if (product[PW-1]) begin
      speed = SPEED_MIN;
    end else begin
      speed = SPEED_MAX;
    end
    speed_mag = speed[Q_W-1] ? (Q_W+1)'(-(Q_W+1)'(speed)) : (Q_W+1)'(speed);
  end

  always_comb begin
    str_e    = ERR_W'(str);
    term_e   = ERR_W'(term);
    target   = ERR_W'(fwd)
             + (STR_ADD[cmd.wheel]  ? str_e  : -str_e)
             + (TERM_ADD[cmd.wheel] ? term_e : -term_e);
    err_next = target - ERR_W'(speed);
  end

  // PWM: magnitude divided by 256 toward zero, clamped, sign restored.
  always_comb begin
    p_neg = product[PW-1];
    p_abs = p_neg ? PW'(-product) : PW'(product);
    p_mag = (|p_abs[PW-1:16]) ? PWM_MAX : p_abs[15:8];
    pwm_next = p_neg ? PWM_W'(-PWM_W'(p_mag)) : PWM_W'(p_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale      <= '0;
      wheel_lever      <= '0;
      prop_gain        <= GAIN_RST;
      moving_threshold <= THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEED_SCALE:      speed_scale      <= cfg_data[SCALE_W-1:0];
        REG_WHEEL_LEVER:      wheel_lever      <= cfg_data[LEVER_W-1:0];
        REG_PROP_GAIN:        prop_gain        <= cfg_data[GAIN_W-1:0];
        REG_MOVING_THRESHOLD: moving_threshold <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WHEELS; i++) begin
        edge_count[i]    <= '0;
        sampled_count[i] <= '0;
      end
    end else begin
      if (cmd.edge_step) begin
        edge_count[in_wheel] <= in_up ? edge_count[in_wheel] + 1'b1
                                      : edge_count[in_wheel] - 1'b1;
      end
      if (cmd.sample) begin
        sampled_count[cmd.wheel] <= edge_count[cmd.wheel];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_ld) begin
      fwd  <= s_tdata[IN_FWD_LSB  +: Q_W];
      str  <= s_tdata[IN_STR_LSB  +: Q_W];
      turn <= s_tdata[IN_TURN_LSB +: Q_W];
    end
    if (cmd.mul_en) begin
      product <= mul_a * mul_b;
    end
    if (cmd.term_ld) begin
      term <= product[32:16];
    end
    if (cmd.err_ld) begin
      err             <= err_next;
      mask[cmd.wheel] <= speed_mag > (Q_W+1)'(moving_threshold);
    end
    if (cmd.pwm_ld) begin
      pwm[cmd.wheel] <= pwm_next;
    end
    if (cmd.out_ld) begin
      out_reg <= {mask, pwm[3], pwm[2], pwm[1], pwm[0]};
    end
  end

  assign out_data = out_reg;

endmodule

// ===== hw/rtl/mwsc_ctrl.sv =====
// Controller of the mecanum wheel speed controller: input handshake, tick
// sequencer over the four wheels and output valid. Uses mwsc_pkg.
module mwsc_ctrl
  import mwsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    s_tuser,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  output dp_cmd_t cmd
);

`include "mecanum_wheel_speed_controller_top_defines.svh"

  state_t             state, state_next;
  logic [WHEEL_W-1:0] wheel_idx, wheel_idx_next;
  logic               out_valid, out_valid_next;
  logic               out_free;

  assign out_free = !out_valid || m_tready;

  always_comb begin
    state_next     = state;
    wheel_idx_next = wheel_idx;
    case (state)
      S_IDLE: begin
        if (s_tvalid && s_tuser) begin
          state_next = S_TERM_MUL;
        end
      end
      S_TERM_MUL:  state_next = S_TERM_LD;
      S_TERM_LD:   state_next = S_SPEED_MUL;
      S_SPEED_MUL: state_next = S_ERR;
      S_ERR:       state_next = S_PWM_MUL;
      S_PWM_MUL:   state_next = S_PWM_LD;
      S_PWM_LD: begin
        wheel_idx_next = wheel_idx + 1'b1;
        state_next = (wheel_idx == WHEEL_W'(WHEELS - 1)) ? S_DONE : S_SPEED_MUL;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = (state == S_IDLE);
    cmd           = '0;
    cmd.mul_sel   = MUL_TERM;
    cmd.wheel     = wheel_idx;
    case (state)
      S_IDLE: begin
        cmd.in_ld     = s_tvalid && s_tuser;
        cmd.edge_step = s_tvalid && !s_tuser;
      end
      S_TERM_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TERM;
      end
      S_TERM_LD: cmd.term_ld = 1'b1;
      S_SPEED_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SPEED;
        cmd.sample  = 1'b1;
      end
      S_ERR: cmd.err_ld = 1'b1;
      S_PWM_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PWM;
      end
      S_PWM_LD: cmd.pwm_ld = 1'b1;
      S_DONE:   cmd.out_ld = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end
    if (cmd.out_ld) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wheel_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wheel_idx <= wheel_idx_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;

  `MWSC_ASSERT_NEXT(a_tick_starts, s_tvalid && s_tready && s_tuser, state == S_TERM_MUL, "tick transaction did not start the sequencer")
  `MWSC_ASSERT_IMPL(a_idle_wheel_zero, state == S_IDLE, wheel_idx == '0, "wheel counter not at zero while idle")
  `MWSC_ASSERT_IMPL(a_no_overwrite, cmd.out_ld, !out_valid || m_tready, "result loaded over a pending result")
  `MWSC_ASSERT_NEXT(a_last_wheel_done, state == S_PWM_LD && wheel_idx == WHEEL_W'(WHEELS - 1), state == S_DONE, "sequencer did not finish after the last wheel")

endmodule
